### src/bis_pkg.sv
// ----------------------------------------------------------------------------
// bis_pkg
// shared constants and types of the block insertion sorter
// ----------------------------------------------------------------------------
package bis_pkg;

   localparam int MaxElements = 64;
   localparam int ValueWidth  = 32;
   localparam int CountWidth  = $clog2(MaxElements + 1);

   typedef logic signed [ValueWidth-1:0] value_type;
   typedef logic [CountWidth-1:0]        count_type;

   // what one cell shows its neighbors
   typedef struct packed {
      logic      valid;
      logic      open;
      value_type value;
   } bis_link_type;

   // chain-wide command
   typedef struct packed {
      logic insert;
      logic shift;
   } bis_ctrl_type;

endpackage

### src/bis_if.sv
// ----------------------------------------------------------------------------
// bis_req_if / bis_rsp_if
// valid/ready channels of the block insertion sorter
// ----------------------------------------------------------------------------
interface bis_req_if
   import bis_pkg::*;
   ;
   logic      valid;
   logic      ready;
   value_type value;
   logic      last;

   modport source (output valid, output value, output last, input ready);
   modport sink   (input valid, input value, input last, output ready);
   modport mon    (input valid, input value, input last, input ready);
endinterface

interface bis_rsp_if
   import bis_pkg::*;
   ;
   logic      valid;
   logic      ready;
   value_type value_res;
   logic      last_res;
   logic      overflow;

   modport source (output valid, output value_res, output last_res, output overflow,
                   input ready);
   modport sink   (input valid, input value_res, input last_res, input overflow,
                   output ready);
   modport mon    (input valid, input value_res, input last_res, input overflow,
                   input ready);
endinterface

### src/bis_cell.sv
// ----------------------------------------------------------------------------
// bis_cell
// one slot of the sorted chain: insert with shift-up, or shift-down on drain
// ----------------------------------------------------------------------------
module bis_cell
   import bis_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  bis_ctrl_type ctrl,
   input  value_type    ins_value,
   input  bis_link_type prev_link,
   input  bis_link_type next_link,
   output bis_link_type own_link
);

   logic      valid_ff, valid_in;
   value_type value_ff, value_in;
   logic      open;

   // strictly greater entries move up, so equal keys keep arrival order
   assign open = !valid_ff || (value_ff > ins_value);

   always_comb begin
      valid_in = valid_ff;
      value_in = value_ff;
      if (ctrl.shift) begin
         valid_in = next_link.valid;
         value_in = next_link.value;
      end else if (ctrl.insert && open) begin
         valid_in = valid_ff || prev_link.valid;
         value_in = prev_link.open ? prev_link.value : ins_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      value_ff <= value_in;
   end

   assign own_link = '{valid: valid_ff, open: open, value: value_ff};

endmodule

### src/block_insertion_sorter.sv
// ----------------------------------------------------------------------------
// block_insertion_sorter
// streaming insertion sorter built from a chain of compare-and-shift cells
// ----------------------------------------------------------------------------
// While no block is emitting, elements are accepted one per cycle; each
// is placed into a chain of MaxElements cells in the cycle it is accepted,
// every larger entry moving up one cell. The beat marked last starts
// emission: the chain then shifts toward cell 0 once per accepted result
// beat, so N stored elements give N result beats, and req ready stays low
// until the final result beat is taken. Elements arriving while the chain
// is full are dropped and every result of that block carries overflow.
module block_insertion_sorter
   import bis_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   bis_req_if.sink   req_if,
   bis_rsp_if.source rsp_if
);

   bis_link_type links [MaxElements];
   bis_ctrl_type ctrl;

   logic      busy_ff, busy_in;
   logic      dropped_ff, dropped_in;
   count_type count_ff, count_in;
   logic      req_fire, rsp_fire, full;

   assign full     = (count_ff == count_type'(MaxElements));
   assign req_fire = req_if.valid && req_if.ready;
   assign rsp_fire = rsp_if.valid && rsp_if.ready;

   assign ctrl = '{insert: req_fire && !full, shift: rsp_fire};

   assign req_if.ready     = !busy_ff;
   assign rsp_if.valid     = busy_ff && links[0].valid;
   assign rsp_if.value_res = links[0].value;
   assign rsp_if.last_res  = !links[1].valid;
   assign rsp_if.overflow  = dropped_ff;

   for (genvar i = 0; i < MaxElements; i++) begin : g_cell
      bis_link_type prev_link, next_link;

      if (i == 0) begin : g_head
         assign prev_link = '{valid: 1'b1, open: 1'b0, value: '0};
      end else begin : g_prev
         assign prev_link = links[i-1];
      end

      if (i == MaxElements - 1) begin : g_tail
         assign next_link = '{valid: 1'b0, open: 1'b0, value: '0};
      end else begin : g_next
         assign next_link = links[i+1];
      end

      bis_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (ctrl),
         .ins_value (req_if.value),
         .prev_link (prev_link),
         .next_link (next_link),
         .own_link  (links[i])
      );
   end

   always_comb begin
      busy_in    = busy_ff;
      dropped_in = dropped_ff;
      count_in   = count_ff;
      if (req_fire) begin
         if (full) begin
            dropped_in = 1'b1;
         end else begin
            count_in = count_ff + count_type'(1);
         end
         if (req_if.last) begin
            busy_in = 1'b1;
         end
      end
      if (rsp_fire && rsp_if.last_res) begin
         busy_in    = 1'b0;
         dropped_in = 1'b0;
         count_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff    <= 1'b0;
         dropped_ff <= 1'b0;
         count_ff   <= '0;
      end else begin
         busy_ff    <= busy_in;
         dropped_ff <= dropped_in;
         count_ff   <= count_in;
      end
   end

endmodule

### src/bis_checker.sv
// ----------------------------------------------------------------------------
// bis_checker
// port-level checks of the block insertion sorter, bound to the top level
// ----------------------------------------------------------------------------
module bis_checker
   import bis_pkg::*;
(
   input logic       clock,
   input logic       reset,
   bis_req_if.sink   req_if,
   bis_rsp_if.source rsp_if
);

   // stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && !rsp_if.ready |=>
         rsp_if.valid && $stable(rsp_if.value_res) && $stable(rsp_if.last_res)
         && $stable(rsp_if.overflow))
      else $error("stalled result beat changed");

   // no input taken during emission
   a_no_req_in_drain: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid |-> !req_if.ready)
      else $error("input ready while results pending");

   // marked input starts emission
   a_last_starts: assert property (@(posedge clock) disable iff (reset)
      req_if.valid && req_if.ready && req_if.last |=> rsp_if.valid)
      else $error("no result after last beat");

   // overflow constant within a block
   a_ovf_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && rsp_if.ready && !rsp_if.last_res |=>
         rsp_if.valid && (rsp_if.overflow == $past(rsp_if.overflow)))
      else $error("overflow changed inside a block");

   // emission ends after the final beat
   a_end_of_block: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && rsp_if.ready && rsp_if.last_res |=> !rsp_if.valid)
      else $error("result after final beat");

endmodule

bind block_insertion_sorter bis_checker u_bis_checker (
   .clock  (clock),
   .reset  (reset),
   .req_if (req_if),
   .rsp_if (rsp_if)
);

### dv/bis_sort_checker.sv
// ----------------------------------------------------------------------------
// bis_sort_checker
// scoreboard for the block insertion sorter
// ----------------------------------------------------------------------------
// Watches both channels. Every accepted element goes into a local sorted
// copy of the block, or flags overflow once the copy is full. The marked
// last element turns that copy into a queue of result beats that are due.
// Each accepted result beat is compared field by field with the oldest due
// beat; failures and the number of beats still due go to the testbench top.
module bis_sort_checker
   import bis_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   bis_req_if.mon    req_if,
   bis_rsp_if.mon    rsp_if,
   output int        failures,
   output int        pending
);

   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      value_type value;
      logic      last;
      logic      overflow;
   } sorted_beat_type;

   sorted_beat_type sorted_beats_due[$];
   value_type       block_copy [MaxElements];
   int              block_count;
   logic            block_dropped;

   function automatic void sort_element(value_type element, logic is_last);
      int              pos;
      sorted_beat_type beat;
      if (block_count < MaxElements) begin
         pos = block_count;
         while (pos > 0 && block_copy[pos-1] > element) begin
            block_copy[pos] = block_copy[pos-1];
            pos--;
         end
         block_copy[pos] = element;
         block_count++;
      end else begin
         block_dropped = 1'b1;
      end
      if (is_last) begin
         for (int k = 0; k < block_count; k++) begin
            beat.value    = block_copy[k];
            beat.last     = (k == block_count - 1);
            beat.overflow = block_dropped;
            sorted_beats_due.push_back(beat);
         end
         block_count   = 0;
         block_dropped = 1'b0;
      end
   endfunction

   function automatic void compare_sorted_beat();
      sorted_beat_type beat;
      if (sorted_beats_due.size() == 0) begin
         $error("result beat with nothing due: value_res %0d last_res %0b overflow %0b",
                rsp_if.value_res, rsp_if.last_res, rsp_if.overflow);
         failures++;
         return;
      end
      beat = sorted_beats_due.pop_front();
      if (rsp_if.value_res !== beat.value) begin
         $error("value_res: expected %0d, actual %0d", beat.value, rsp_if.value_res);
         failures++;
      end
      if (rsp_if.last_res !== beat.last) begin
         $error("last_res: expected %0b, actual %0b", beat.last, rsp_if.last_res);
         failures++;
      end
      if (rsp_if.overflow !== beat.overflow) begin
         $error("overflow: expected %0b, actual %0b", beat.overflow, rsp_if.overflow);
         failures++;
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         sorted_beats_due.delete();
         block_count   = 0;
         block_dropped = 1'b0;
         failures      = 0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) compare_sorted_beat();
         if (req_if.valid && req_if.ready) sort_element(req_if.value, req_if.last);
      end
      pending <= sorted_beats_due.size();
   end

endmodule

### dv/tb_block_insertion_sorter.sv
// ----------------------------------------------------------------------------
// tb_block_insertion_sorter
// testbench top of the block insertion sorter
// ----------------------------------------------------------------------------
// Sends blocks of signed elements: a few hand-picked blocks with extreme,
// duplicate and descending values, a block that just fills the store, one
// that overflows it, dropping its last two elements, then random blocks of
// mostly small and a few oversized lengths. Both channels idle at random.
// The scoreboard beside the block predicts and compares every result beat.
module tb_block_insertion_sorter;

   import bis_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam value_type ValueMax = value_type'(32'h7fff_ffff);
   localparam value_type ValueMin = value_type'(32'h8000_0000);

   logic clock = 1'b0;
   logic reset;
   int   failures;
   int   pending;
   int   elements_sent;
   bit   gaps_on;
   bit   stalls_on;

   bis_req_if req_if ();
   bis_rsp_if rsp_if ();

   block_insertion_sorter dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if.sink),
      .rsp_if (rsp_if.source)
   );

   bis_sort_checker sort_check (
      .clock    (clock),
      .reset    (reset),
      .req_if   (req_if.mon),
      .rsp_if   (rsp_if.mon),
      .failures (failures),
      .pending  (pending)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   initial begin
      #2_000_000;
      $display("FAIL");
      $finish;
   end

   // mostly short gaps, a few long ones
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic value_type pick_value();
      int r;
      r = $urandom_range(0, 9);
      case (r)
         0: begin
            case ($urandom_range(0, 3))
               0: return ValueMin;
               1: return ValueMax;
               2: return value_type'(0);
               default: return value_type'(-1);
            endcase
         end
         1, 2, 3: return value_type'($signed($urandom_range(0, 8)) - 4);
         default: return value_type'($urandom);
      endcase
   endfunction

   task automatic send_element(value_type element, logic is_last);
      int gap;
      gap = gaps_on ? pick_gap() : 0;
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.value <= element;
      req_if.last  <= is_last;
      do @(posedge clock); while (!req_if.ready);
      elements_sent++;
   endtask

   task automatic send_block(int length);
      for (int i = 0; i < length; i++) send_element(pick_value(), i == length - 1);
   endtask

   task automatic wait_until_drained();
      req_if.valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   // result side back-pressure
   initial begin
      int stall;
      forever begin
         rsp_if.ready <= 1'b1;
         repeat ($urandom_range(1, 16)) @(posedge clock);
         stall = pick_gap();
         if (stalls_on && stall > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
      end
   end

   initial begin
      int length;
      req_if.valid  <= 1'b0;
      req_if.value  <= '0;
      req_if.last   <= 1'b0;
      reset         <= 1'b1;
      elements_sent  = 0;
      gaps_on        = 1'b1;
      stalls_on      = 1'b1;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // single element, sign extremes, duplicates, descending run
      send_element(ValueMax, 1'b1);
      send_element(ValueMin, 1'b0);
      send_element(ValueMax, 1'b0);
      send_element(value_type'(0), 1'b0);
      send_element(value_type'(-1), 1'b0);
      send_element(value_type'(1), 1'b1);
      send_element(value_type'(7), 1'b0);
      send_element(value_type'(-7), 1'b0);
      send_element(value_type'(7), 1'b0);
      send_element(value_type'(7), 1'b1);
      send_element(value_type'(3), 1'b0);
      send_element(value_type'(2), 1'b0);
      send_element(value_type'(1), 1'b1);
      wait_until_drained();

      // full store, then overflow with the last two elements dropped, at full rate
      gaps_on   = 1'b0;
      stalls_on = 1'b0;
      send_block(MaxElements);
      send_block(MaxElements + 2);
      wait_until_drained();

      while (elements_sent < 260) begin
         gaps_on   = ($urandom_range(0, 3) != 0);
         stalls_on = ($urandom_range(0, 3) != 0);
         length = ($urandom_range(0, 99) < 6) ? $urandom_range(MaxElements - 4, MaxElements + 6)
                                               : $urandom_range(1, 12);
         send_block(length);
         if ($urandom_range(0, 9) == 0) wait_until_drained();
      end

      wait_until_drained();
      repeat (2 * MaxElements) @(posedge clock);
      if (failures == 0 && pending == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

### filelist.f
src/bis_pkg.sv
src/bis_if.sv
src/bis_cell.sv
src/block_insertion_sorter.sv
src/bis_checker.sv
dv/bis_sort_checker.sv
dv/tb_block_insertion_sorter.sv
